// ===== src/nmea_sentence_checksum_detector_macros.svh =====
// Assertion macros used by the checker file of the NMEA checksum detector.
`ifndef NMEA_SENTENCE_CHECKSUM_DETECTOR_MACROS_SVH
`define NMEA_SENTENCE_CHECKSUM_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSCD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("nscd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NSCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("nscd assertion failed");

`endif

// ===== src/nscd_pkg.sv =====
// Package with the types, character codes and hex decode of the NMEA checksum detector.
package nscd_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChStar   = 8'h2A;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] rx_byte;
  } nscd_stage_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } nscd_hex_t;

  function automatic nscd_hex_t hex_decode(input logic [ByteW-1:0] b);
    nscd_hex_t    r;
    logic [ByteW-1:0] t;
    r = '0;
    t = '0;
    if (b inside {[8'h30:8'h39]}) begin
      t       = b - 8'h30;
      r.valid = 1'b1;
      r.value = t[3:0];
    end else if (b inside {[8'h41:8'h46]}) begin
      t       = b - 8'h37;
      r.valid = 1'b1;
      r.value = t[3:0];
    end else if (b inside {[8'h61:8'h66]}) begin
      t       = b - 8'h57;
      r.valid = 1'b1;
      r.value = t[3:0];
    end
    return r;
  endfunction

endpackage

// ===== src/nscd_in_stage.sv =====
// Input register stage that holds one received byte until the checksum core takes it.
module nscd_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [nscd_pkg::ByteW-1:0] s_axis_tdata,
  input  logic                       pop_i,
  output nscd_pkg::nscd_stage_t      stage_o
);
  import nscd_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             take;

  assign s_axis_tready = !valid_q || pop_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= s_axis_tdata;
    end
  end

  assign stage_o.valid   = valid_q;
  assign stage_o.rx_byte = byte_q;

endmodule

// ===== src/nscd_core.sv =====
// Sentence state, running parity, character history and checksum compare.
module nscd_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [nscd_pkg::ByteW-1:0] rx_byte_i,
  output logic                       sentence_ok_o
);
  import nscd_pkg::*;

  logic             in_q, in_d;
  logic [ByteW-1:0] par_q, par_d;
  logic [ByteW-1:0] hist_q [3];
  logic [ByteW-1:0] hist_d [3];
  logic             is_eol;
  nscd_hex_t        hi, lo;
  logic [ByteW-1:0] sum;

  assign is_eol = (rx_byte_i == ChCr) || (rx_byte_i == ChLf);
  assign hi     = hex_decode(hist_q[1]);
  assign lo     = hex_decode(hist_q[2]);
  assign sum    = par_q ^ hist_q[0] ^ hist_q[1] ^ hist_q[2];

  assign sentence_ok_o = in_q && is_eol && (hist_q[0] == ChStar) && hi.valid && lo.valid
                         && (sum == {hi.value, lo.value});

  always_comb begin
    in_d   = in_q;
    par_d  = par_q;
    hist_d = hist_q;
    if (in_q) begin
      if (is_eol) begin
        in_d = 1'b0;
      end else begin
        par_d     = par_q ^ rx_byte_i;
        hist_d[0] = hist_q[1];
        hist_d[1] = hist_q[2];
        hist_d[2] = rx_byte_i;
      end
    end else if (rx_byte_i == ChDollar) begin
      in_d  = 1'b1;
      par_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q   <= 1'b0;
      par_q  <= '0;
      hist_q <= '{default: '0};
    end else if (en_i) begin
      in_q   <= in_d;
      par_q  <= par_d;
      hist_q <= hist_d;
    end
  end

endmodule

// ===== src/nmea_sentence_checksum_detector.sv =====
// Each byte passes the input register, then the result register holds its result for the sink.
// Throughput: one byte per cycle while the sink takes results; the sentence state updates once per byte.
// An input register and a result register part the two sides, so input is taken
// while a finished result waits for the sink.
// Reset (rst_ni low, asynchronous) leaves the block outside any sentence with
// zero parity, an all-zero history and both stages empty.
module nmea_sentence_checksum_detector (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] sentence_ok, [7:1] zero
);
  import nscd_pkg::*;

  nscd_stage_t stage;
  logic        pop;
  logic        ok;
  logic        out_valid_q, out_valid_d;
  logic        ok_q;

  assign pop = stage.valid && (!out_valid_q || m_axis_tready);

  nscd_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .pop_i         (pop),
    .stage_o       (stage)
  );

  nscd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (pop),
    .rx_byte_i     (stage.rx_byte),
    .sentence_ok_o (ok)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ok_q <= ok;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, ok_q};

endmodule

// ===== src/nscd_checker.sv =====
// Port checker for the NMEA checksum detector and its bind to the top level.
`include "nmea_sentence_checksum_detector_macros.svh"

module nscd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  `NSCD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `NSCD_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `NSCD_ASSERT_IMPLY(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[7:1] == 7'b0)
  `NSCD_ASSERT_IMPLY(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

endmodule

bind nmea_sentence_checksum_detector nscd_checker u_nscd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
